// ===== src/es2u_pkg.sv =====
// shared types, constants and calendar helpers for the epoch seconds to utc calendar block
// no dependencies; used by the rules table, the top level and the checker
`default_nettype none

package es2u_pkg;

  localparam int SECS_W = 25;
  localparam logic [SECS_W-1:0] SEC_PER_DAY  = SECS_W'(24 * 60 * 60);
  localparam logic [SECS_W-1:0] SEC_PER_HOUR = SECS_W'(60 * 60);
  localparam logic [SECS_W-1:0] SEC_PER_MIN  = SECS_W'(60);
  localparam logic [SECS_W-1:0] SEC_PER_YEAR = SECS_W'(365 * 24 * 60 * 60);
  localparam logic [SECS_W-1:0] SEC_PER_LYEAR = SECS_W'(366 * 24 * 60 * 60);

  localparam int EPOCH_YEAR   = 1970;
  localparam int YEAR_BASE    = 1900;
  localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);
  localparam logic [8:0] LAST_MOD400  = 9'(399);
  localparam logic [2:0] EPOCH_WDAY   = 3'd4;

  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_DEC = 4'd11;

  localparam int OUT_TDATA_W = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR_FWD,
    ST_YEAR_BACK,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MINUTE,
    ST_FINISH
  } es2u_state_t;

  // calendar facts for the year and month under the sequencer
  typedef struct packed {
    logic              leap_year;
    logic [SECS_W-1:0] year_secs;
    logic [4:0]        mon_day_count;
    logic [SECS_W-1:0] month_secs;
  } es2u_rule_t;

  // leap seconds by year offset from 1970: bit 0 end of june, bit 1 end of december
  function automatic logic [1:0] leap_row(input logic [7:0] idx);
    logic [1:0] row;
    unique case (idx)
      8'd2:                                     row = 2'd3;
      8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9: row = 2'd2;
      8'd11, 8'd12, 8'd13, 8'd15:               row = 2'd1;
      8'd17, 8'd19, 8'd20:                      row = 2'd2;
      8'd22, 8'd23, 8'd24, 8'd27:               row = 2'd1;
      8'd25, 8'd28, 8'd35, 8'd38:               row = 2'd2;
      8'd42:                                    row = 2'd1;
      default:                                  row = 2'd0;
    endcase
    return row;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    unique case (mon)
      4'd1:                    d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [SECS_W-1:0] days_secs(input logic [4:0] d);
    logic [SECS_W-1:0] s;
    unique case (d)
      5'd28:   s = SECS_W'(28 * 24 * 60 * 60);
      5'd29:   s = SECS_W'(29 * 24 * 60 * 60);
      5'd30:   s = SECS_W'(30 * 24 * 60 * 60);
      default: s = SECS_W'(31 * 24 * 60 * 60);
    endcase
    return s;
  endfunction

  function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [1:0] k);
    logic [3:0] s;
    s = {1'b0, w} + {2'b0, k};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  function automatic logic [2:0] wday_sub(input logic [2:0] w, input logic [1:0] k);
    logic [3:0] s;
    s = {1'b0, w} + 4'd7 - {2'b0, k};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/es2u_alu.sv =====
// shared add/subtract unit with sign flag, used for every year, month and unit step
// depends on nothing
`default_nettype none

module es2u_alu #(
  parameter int W = 36
) (
  input  wire logic signed [W-1:0] a,
  input  wire logic        [W-1:0] b,
  input  wire logic                sub,
  output logic signed      [W-1:0] res,
  output logic                     neg
);

  always_comb begin
    res = sub ? (a - $signed(b)) : (a + $signed(b));
    neg = res[W-1];
  end

endmodule

`default_nettype wire

// ===== src/es2u_rules.sv =====
// gregorian and leap second rules: year length, month length and month length in seconds
// depends on es2u_pkg
`default_nettype none

module es2u_rules #(
  parameter int TABLE_YEARS = 44,
  parameter int YW          = 14
) (
  input  wire logic        [8:0]    year_mod400,
  input  wire logic signed [YW-1:0] year_off,
  input  wire logic        [3:0]    mon,
  output es2u_pkg::es2u_rule_t      rule
);
  import es2u_pkg::*;

  logic       ly;
  logic       in_tab;
  logic [1:0] row;
  logic       mon_leap;

  always_comb begin
    ly     = (year_mod400[1:0] == 2'd0) && (year_mod400 != 9'd100) &&
             (year_mod400 != 9'd200) && (year_mod400 != 9'd300);
    in_tab = !year_off[YW-1] && (year_off < YW'(TABLE_YEARS));
    row    = in_tab ? leap_row(year_off[7:0]) : 2'd0;
    if (mon == MON_JUN) begin
      mon_leap = row[0];
    end else if (mon == MON_DEC) begin
      mon_leap = row[1];
    end else begin
      mon_leap = 1'b0;
    end
    rule.leap_year     = ly;
    rule.year_secs     = (ly ? SEC_PER_LYEAR : SEC_PER_YEAR) + SECS_W'(row[0]) +
                         SECS_W'(row[1]);
    rule.mon_day_count = month_len(mon, ly);
    rule.month_secs    = days_secs(rule.mon_day_count) + SECS_W'(mon_leap);
  end

endmodule

`default_nettype wire

// ===== src/epoch_seconds_to_utc_calendar.sv =====
// sequence: the year is stepped from 1970, then the month, then whole days, hours and
//   minutes, with one add or subtract on the shared unit per step
// one word is converted at a time, as the single shared add/subtract unit serves every step
// a finished word sits in the output register; the next word is taken once it is loaded
// reset: rst_n synchronous, active low, returns the sequencer to idle and drops out_tvalid
`default_nettype none

module epoch_seconds_to_utc_calendar #(
  parameter int TABLE_YEARS   = 44,
  parameter int SECONDS_WIDTH = 36
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // [SECONDS_WIDTH-1:0] epoch_seconds, zero padding above
  input  wire logic [((SECONDS_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // [11:0] year_since_1900, [15:12] month_index, [20:16] day_of_month,
  // [25:21] hour_of_day, [31:26] minute_of_hour, [37:32] second_of_minute,
  // [40:38] weekday, [49:41] day_of_year, zero padding above
  output logic [es2u_pkg::OUT_TDATA_W-1:0]            out_tdata
);
  import es2u_pkg::*;

  localparam int SW = SECONDS_WIDTH;
  localparam int YW = (SW - 22 > 12) ? SW - 22 : 12;

  es2u_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic signed [SW-1:0] left_r, left_nxt;
  logic signed [YW-1:0] yoff_r, yoff_nxt;
  logic [8:0]           m400_r, m400_nxt;
  logic [2:0]           wday_r, wday_nxt;
  logic [8:0]           yday_r, yday_nxt;
  logic [3:0]           mon_r, mon_nxt;
  logic [4:0]           mday_r, mday_nxt;
  logic [4:0]           hour_r, hour_nxt;
  logic [5:0]           min_r, min_nxt;
  logic                 leap_r, leap_nxt;
  logic [OUT_TDATA_W-1:0] out_r, out_nxt;

  logic signed [YW-1:0] yoff_q;
  logic [8:0]           m400_q;
  es2u_rule_t           rule;

  logic signed [SW-1:0] alu_res;
  logic [SW-1:0]        alu_b;
  logic                 alu_sub;
  logic                 alu_neg;

  logic [11:0] year_out;
  logic [4:0]  mday_out;
  logic [4:0]  hour_out;
  logic [5:0]  min_out;
  logic [5:0]  sec_out;

  // backward steps look at the year before the current one
  always_comb begin
    if (state_r == ST_YEAR_BACK) begin
      yoff_q = yoff_r - YW'(1);
      m400_q = (m400_r == 9'd0) ? LAST_MOD400 : m400_r - 9'd1;
    end else begin
      yoff_q = yoff_r;
      m400_q = m400_r;
    end
  end

  es2u_rules #(
    .TABLE_YEARS (TABLE_YEARS),
    .YW          (YW)
  ) u_rules (
    .year_mod400 (m400_q),
    .year_off    (yoff_q),
    .mon         (mon_r),
    .rule        (rule)
  );

  es2u_alu #(
    .W (SW)
  ) u_alu (
    .a   (left_r),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .neg (alu_neg)
  );

  always_comb begin
    alu_sub = 1'b1;
    unique case (state_r)
      ST_YEAR_FWD: begin
        alu_b = SW'(rule.year_secs);
      end
      ST_YEAR_BACK: begin
        alu_b   = SW'(rule.year_secs);
        alu_sub = 1'b0;
      end
      ST_MONTH:  alu_b = SW'(rule.month_secs);
      ST_DAY:    alu_b = SW'(SEC_PER_DAY);
      ST_HOUR:   alu_b = SW'(SEC_PER_HOUR);
      ST_MINUTE: alu_b = SW'(SEC_PER_MIN);
      default:   alu_b = SW'(SEC_PER_MIN);
    endcase
  end

  always_comb begin
    year_out = 12'(yoff_r + YW'(EPOCH_YEAR - YEAR_BASE));
    mday_out = leap_r ? mday_r : mday_r + 5'd1;
    hour_out = leap_r ? 5'd23 : hour_r;
    min_out  = leap_r ? 6'd59 : min_r;
    sec_out  = leap_r ? 6'd60 : left_r[5:0];
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    left_nxt      = left_r;
    yoff_nxt      = yoff_r;
    m400_nxt      = m400_r;
    wday_nxt      = wday_r;
    yday_nxt      = yday_r;
    mon_nxt       = mon_r;
    mday_nxt      = mday_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    leap_nxt      = leap_r;
    out_nxt       = out_r;
    in_tready     = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          left_nxt  = $signed(in_tdata[SW-1:0]);
          yoff_nxt  = '0;
          m400_nxt  = EPOCH_MOD400;
          wday_nxt  = EPOCH_WDAY;
          yday_nxt  = '0;
          mon_nxt   = '0;
          mday_nxt  = '0;
          hour_nxt  = '0;
          min_nxt   = '0;
          leap_nxt  = 1'b0;
          state_nxt = in_tdata[SW-1] ? ST_YEAR_BACK : ST_YEAR_FWD;
        end
      end
      ST_YEAR_FWD: begin
        if (!alu_neg) begin
          left_nxt = alu_res;
          yoff_nxt = yoff_r + YW'(1);
          m400_nxt = (m400_r == LAST_MOD400) ? 9'd0 : m400_r + 9'd1;
          wday_nxt = wday_add(wday_r, rule.leap_year ? 2'd2 : 2'd1);
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_YEAR_BACK: begin
        left_nxt = alu_res;
        yoff_nxt = yoff_q;
        m400_nxt = m400_q;
        wday_nxt = wday_sub(wday_r, rule.leap_year ? 2'd2 : 2'd1);
        if (!alu_neg) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (mon_r == MON_DEC || alu_neg) begin
          state_nxt = ST_DAY;
        end else begin
          left_nxt = alu_res;
          yday_nxt = yday_r + 9'(rule.mon_day_count);
          wday_nxt = wday_add(wday_r, 2'(rule.mon_day_count - 5'd28));
          mon_nxt  = mon_r + 4'd1;
        end
      end
      ST_DAY: begin
        if (!alu_neg) begin
          left_nxt = alu_res;
          mday_nxt = mday_r + 5'd1;
          yday_nxt = yday_r + 9'd1;
          wday_nxt = wday_add(wday_r, 2'd1);
        end else if (mday_r == rule.mon_day_count) begin
          // inserted leap second: back up to the last day of the month
          leap_nxt  = 1'b1;
          yday_nxt  = yday_r - 9'd1;
          wday_nxt  = wday_sub(wday_r, 2'd1);
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_HOUR;
        end
      end
      ST_HOUR: begin
        if (!alu_neg) begin
          left_nxt = alu_res;
          hour_nxt = hour_r + 5'd1;
        end else begin
          state_nxt = ST_MINUTE;
        end
      end
      ST_MINUTE: begin
        if (!alu_neg) begin
          left_nxt = alu_res;
          min_nxt  = min_r + 6'd1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = {6'd0, yday_r, wday_r, sec_out, min_out, hour_out, mday_out,
                           mon_r, year_out};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    yoff_r <= yoff_nxt;
    m400_r <= m400_nxt;
    wday_r <= wday_nxt;
    yday_r <= yday_nxt;
    mon_r  <= mon_nxt;
    mday_r <= mday_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    leap_r <= leap_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

`default_nettype wire

// ===== src/es2u_checker.sv =====
// port-level checks for epoch_seconds_to_utc_calendar, attached by bind
// depends on es2u_pkg and the top level's port list
`default_nettype none

module es2u_checker #(
  parameter int SECONDS_WIDTH = 36
) (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   in_tvalid,
  input wire logic                                   in_tready,
  input wire logic [((SECONDS_WIDTH+7)/8)*8-1:0]     in_tdata,
  input wire logic                                   out_tvalid,
  input wire logic                                   out_tready,
  input wire logic [es2u_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import es2u_pkg::*;

  // a waiting input word is held until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input word changed while waiting");

  // a held word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // the unit is not ready in the cycle after it takes a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a word");

  // calendar fields stay within their ranges
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] <= 4'd11) && (out_tdata[20:16] != 5'd0) &&
                   (out_tdata[25:21] <= 5'd23) && (out_tdata[31:26] <= 6'd59) &&
                   (out_tdata[37:32] <= 6'd60) && (out_tdata[40:38] <= 3'd6) &&
                   (out_tdata[49:41] <= 9'd365))
    else $error("calendar field out of range");

  // a leap second only shows at 23:59 in june or december
  a_leap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[37:32] == 6'd60) |->
      (out_tdata[25:21] == 5'd23) && (out_tdata[31:26] == 6'd59) &&
      ((out_tdata[15:12] == MON_JUN) || (out_tdata[15:12] == MON_DEC)))
    else $error("leap second outside 23:59 at end of june or december");

endmodule

bind epoch_seconds_to_utc_calendar es2u_checker #(
  .SECONDS_WIDTH (SECONDS_WIDTH)
) u_es2u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== test/tb.sv =====
// testbench for epoch_seconds_to_utc_calendar: drives timestamps and checks every calendar
// word against a predictor kept in this file; depends on es2u_pkg and the block itself
`default_nettype none

module tb;
  import es2u_pkg::*;

  localparam int SECS_BITS   = 36;
  localparam int TABLE_YEARS = 44;
  localparam int IN_W        = ((SECS_BITS + 7) / 8) * 8;
  localparam int DAY_SECS    = 24 * 60 * 60;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 1300;

  // leap seconds per year from 1970: bit 0 end of june, bit 1 end of december
  localparam bit [1:0] LEAP_SECOND_ROWS [0:TABLE_YEARS-1] = '{
    2'd0, 2'd0, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd0
  };

  // listed from the highest bits down, so year lands in the lowest bits
  typedef struct packed {
    logic [8:0]  yday;
    logic [2:0]  wday;
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  calendar_t calendar_expected[$];
  bit  idle_en = 1'b1;
  int  fail_count = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  leap_second_words = 0;
  int  pre_epoch_words = 0;
  int  out_stall_left = 0;
  int  quiet_cycles = 0;

  epoch_seconds_to_utc_calendar #(
    .TABLE_YEARS  (TABLE_YEARS),
    .SECONDS_WIDTH(SECS_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit gregorian_leap(input longint y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic longint inserted_seconds(input longint y, input int m);
    longint idx;
    bit [1:0] row;
    idx = y - EPOCH_YEAR;
    if (idx < 0 || idx >= TABLE_YEARS) return 0;
    row = LEAP_SECOND_ROWS[idx];
    if (m == int'(MON_JUN)) return row[0];
    if (m == int'(MON_DEC)) return row[1];
    return 0;
  endfunction

  function automatic longint year_day_count(input longint y);
    return gregorian_leap(y) ? 366 : 365;
  endfunction

  function automatic longint seconds_in_year(input longint y);
    return year_day_count(y) * DAY_SECS + inserted_seconds(y, MON_JUN)
           + inserted_seconds(y, MON_DEC);
  endfunction

  function automatic longint days_in_month(input longint y, input int m);
    case (m)
      1:           return gregorian_leap(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic longint seconds_in_month(input longint y, input int m);
    return days_in_month(y, m) * DAY_SECS + inserted_seconds(y, m);
  endfunction

  // epoch seconds at the first instant of month m of year y; m of 12 means next january
  function automatic longint month_start(input longint y, input int m);
    longint s;
    longint k;
    int j;
    s = 0;
    for (k = EPOCH_YEAR; k < y; k++) s += seconds_in_year(k);
    for (k = y; k < EPOCH_YEAR; k++) s -= seconds_in_year(k);
    for (j = 0; j < m; j++) s += seconds_in_month(y, j);
    return s;
  endfunction

  function automatic calendar_t to_calendar(input logic signed [SECS_BITS-1:0] secs);
    longint left, year, wday, yday, d, ms, mday, hour, minute, sec, md;
    int mon;
    calendar_t r;
    left = secs;
    year = EPOCH_YEAR;
    wday = EPOCH_WDAY;
    yday = 0;
    mon = 0;
    while (left > 0) begin
      if (seconds_in_year(year) > left) break;
      left -= seconds_in_year(year);
      wday = (wday + year_day_count(year)) % 7;
      year++;
    end
    while (left < 0) begin
      year--;
      left += seconds_in_year(year);
      wday = (wday + 7 - year_day_count(year) % 7) % 7;
    end
    while (mon < 11) begin
      d = days_in_month(year, mon);
      ms = seconds_in_month(year, mon);
      if (ms > left) break;
      left -= ms;
      yday += d;
      wday = (wday + d) % 7;
      mon++;
    end
    md = days_in_month(year, mon);
    mday = left / DAY_SECS;
    left = left % DAY_SECS;
    if (mday < md) begin
      hour = left / 3600;
      left = left % 3600;
      minute = left / 60;
      sec = left % 60;
    end else begin
      // the inserted second of the month reads 23:59:60 on its last day
      mday = md - 1;
      hour = 23;
      minute = 59;
      sec = 60;
    end
    yday += mday;
    wday = (wday + mday) % 7;
    r.year   = 12'(year - YEAR_BASE);
    r.month  = 4'(mon);
    r.mday   = 5'(mday + 1);
    r.hour   = 5'(hour);
    r.minute = 6'(minute);
    r.sec    = 6'(sec);
    r.wday   = 3'(wday);
    r.yday   = 9'(yday);
    return r;
  endfunction

  // ---------------------------------------------------------------- driving and checking

  task automatic send_timestamp(input longint secs);
    logic signed [SECS_BITS-1:0] word;
    word = secs[SECS_BITS-1:0];
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-SECS_BITS){1'b0}}, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    calendar_expected.push_back(to_calendar(word));
    words_sent++;
    if (word < 0) pre_epoch_words++;
  endtask

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    calendar_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = calendar_t'(out_tdata[49:0]);
      if (calendar_expected.size() == 0) begin
        $error("calendar word with no timestamp pending: %h", out_tdata);
        fail_count++;
      end else begin
        want = calendar_expected.pop_front();
        check_field("year_since_1900", $signed(want.year), $signed(got.year));
        check_field("month_index", want.month, got.month);
        check_field("day_of_month", want.mday, got.mday);
        check_field("hour_of_day", want.hour, got.hour);
        check_field("minute_of_hour", want.minute, got.minute);
        check_field("second_of_minute", want.sec, got.sec);
        check_field("weekday", want.wday, got.wday);
        check_field("day_of_year", want.yday, got.yday);
      end
      words_checked++;
      if (got.sec == 6'd60) leap_second_words++;
    end
  end

  // random downstream backpressure in bursts, started only while idle_en is set
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_tready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      out_stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d cycles with no word moving", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_epoch_edges();
    send_timestamp(0);
    send_timestamp(-1);
    send_timestamp(1);
    send_timestamp(DAY_SECS - 1);
    send_timestamp(DAY_SECS);
    send_timestamp((longint'(1) << (SECS_BITS - 1)) - 1);
    send_timestamp(-(longint'(1) << (SECS_BITS - 1)));
  endtask

  // instant before, on and after the inserted second
  task automatic test_leap_seconds();
    longint t;
    t = month_start(1972, int'(MON_JUN) + 1) - 1;
    send_timestamp(t - 1);
    send_timestamp(t);
    send_timestamp(t + 1);
    t = month_start(1972, int'(MON_DEC) + 1) - 1;
    send_timestamp(t - 1);
    send_timestamp(t);
    send_timestamp(t + 1);
    t = month_start(2012, int'(MON_JUN) + 1) - 1;
    send_timestamp(t - 1);
    send_timestamp(t);
    send_timestamp(t + 1);
  endtask

  // century rules, and year ends at and past the last table row
  task automatic test_calendar_rules();
    send_timestamp(month_start(2000, int'(MON_FEB)) + 28 * DAY_SECS);
    send_timestamp(month_start(1900, int'(MON_FEB) + 1) - 1);
    send_timestamp(month_start(2100, int'(MON_FEB) + 1) - 1);
    send_timestamp(month_start(2014, 0) - 1);
    send_timestamp(month_start(2017, 0) - 1);
    send_timestamp(month_start(2017, 0));
  endtask

  task automatic test_random_mix(input int count);
    longint t;
    int idx, mon;
    bit [1:0] row;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          t = longint'($signed(36'({$urandom, $urandom})));
        end
        3, 4: begin
          // about 136 years either side of the epoch, spanning the table years and well past them
          t = longint'({$urandom_range(0, 1), $urandom}) - (longint'(1) << 32);
        end
        5, 6: begin
          do idx = $urandom_range(0, TABLE_YEARS - 1); while (LEAP_SECOND_ROWS[idx] == 2'd0);
          row = LEAP_SECOND_ROWS[idx];
          if (row == 2'd3) mon = $urandom_range(0, 1) ? int'(MON_DEC) : int'(MON_JUN);
          else mon = row[0] ? int'(MON_JUN) : int'(MON_DEC);
          t = month_start(EPOCH_YEAR + idx, mon + 1) - 1 + longint'($urandom_range(0, 4)) - 2;
        end
        default: begin
          t = month_start($urandom_range(900, 3000), $urandom_range(0, 11))
              + longint'($urandom_range(0, 4)) - 2;
        end
      endcase
      send_timestamp(t);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_epoch_edges();
    test_leap_seconds();
    test_calendar_rules();
    test_random_mix(400);
    idle_en = 1'b0;
    test_random_mix(100);
    in_tvalid <= 1'b0;
    while (calendar_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("converted %0d timestamps, %0d before 1970, checked %0d calendar words",
             words_sent, pre_epoch_words, words_checked);
    $display("%0d words landed on an inserted leap second", leap_second_words);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
